// ===== design/bbaf_pkg.sv =====
// Shared types, codes and constants for the beacon advertising filter.
package bbaf_pkg;

    localparam int MAX_AD_BYTES_DEF = 255;
    localparam int MIN_PAYLOAD      = 25;
    localparam int MATCH_BYTES      = 25;
    localparam int UUID_BYTES       = 16;
    localparam int UUID_WORDS       = 4;

    localparam logic [7:0]  TYPE_MFG   = 8'hFF;
    localparam logic [7:0]  SUBTYPE    = 8'h02;
    localparam logic [7:0]  BEACON_LEN = 8'h15;

    localparam logic [15:0] COMPANY_RST = 16'h004C;
    localparam logic [31:0] UUID0_RST   = 32'h1615EE18;
    localparam logic [31:0] UUID1_RST   = 32'h6B01EC4B;
    localparam logic [31:0] UUID2_RST   = 32'h96ADBCB9;
    localparam logic [31:0] UUID3_RST   = 32'h6D166E66;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_INVALID = 2'd1,
        ST_NODATA  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPANY = 3'd0,
        CFG_UUID0   = 3'd1,
        CFG_UUID1   = 3'd2,
        CFG_UUID2   = 3'd3,
        CFG_UUID3   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]                company_code;
        logic [UUID_BYTES-1:0][7:0] uuid;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [15:0] x_hundredths;
        logic [15:0] y_hundredths;
    } t_result;

endpackage

// ===== design/ble_beacon_advert_filter.sv =====
// Top level of the beacon advertising filter: input register, walker, result register.
// The last byte of a payload steps the walker from the input register, loading the result
// register; that byte waits in the input register while a result beat is stalled.
// Throughput: one payload byte per cycle, set by the walker update, save for that wait.
// Reset is synchronous and active low; it clears the walk, the handshake state and
// returns the configuration registers to their defaults.
module ble_beacon_advert_filter #(
    parameter int MAX_AD_BYTES = bbaf_pkg::MAX_AD_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // ad_byte
    input  logic                                i_s_tlast,   // last_byte
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // status [1:0], x_hundredths [17:2], y_hundredths [33:18], zero fill [39:34]
    output logic [bbaf_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bbaf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bbaf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    bbaf_pkg::t_result r_out;
    logic              advance;
    bbaf_pkg::t_cfg    cfg;
    bbaf_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    bbaf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bbaf_walk #(
        .MAX_AD_BYTES (MAX_AD_BYTES)
    ) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.y_hundredths, r_out.x_hundredths, r_out.status};

endmodule

// ===== design/bbaf_cfg.sv =====
// Configuration registers: company identifier and target UUID words.
module bbaf_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [bbaf_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [bbaf_pkg::CFG_DATA_W-1:0]  i_data,
    output bbaf_pkg::t_cfg                   o_cfg
);

    logic [15:0] r_company;
    logic [bbaf_pkg::UUID_WORDS-1:0][31:0] r_uuid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_company <= bbaf_pkg::COMPANY_RST;
            r_uuid[0] <= bbaf_pkg::UUID0_RST;
            r_uuid[1] <= bbaf_pkg::UUID1_RST;
            r_uuid[2] <= bbaf_pkg::UUID2_RST;
            r_uuid[3] <= bbaf_pkg::UUID3_RST;
        end else if (i_we) begin
            case (bbaf_pkg::t_cfg_idx'(i_index))
                bbaf_pkg::CFG_COMPANY: r_company <= i_data[15:0];
                bbaf_pkg::CFG_UUID0:   r_uuid[0] <= i_data;
                bbaf_pkg::CFG_UUID1:   r_uuid[1] <= i_data;
                bbaf_pkg::CFG_UUID2:   r_uuid[2] <= i_data;
                bbaf_pkg::CFG_UUID3:   r_uuid[3] <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.company_code = r_company;

    for (genvar g = 0; g < bbaf_pkg::UUID_BYTES; g++) begin : g_uuid
        assign o_cfg.uuid[g] = r_uuid[g / 4][31 - 8 * (g % 4) -: 8];
    end

endmodule

// ===== design/bbaf_walk.sv =====
// Record walker: per-byte state update and the result of a finished payload.
module bbaf_walk #(
    parameter int MAX_AD_BYTES = bbaf_pkg::MAX_AD_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  bbaf_pkg::t_cfg    i_cfg,
    output bbaf_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(MAX_AD_BYTES + 1);

    logic [CNT_W-1:0]  r_bytes_seen, n_bytes_seen;
    logic              r_expect_length, n_expect_length;
    logic [7:0]        r_record_left, n_record_left;
    logic [4:0]        r_record_pos, n_record_pos;
    logic              r_record_is_mfg, n_record_is_mfg;
    logic              r_match_so_far, n_match_so_far;
    logic [15:0]       r_major, n_major;
    logic [15:0]       r_minor, n_minor;
    bbaf_pkg::t_status r_outcome, n_outcome;
    logic              r_decided, n_decided;

    logic              ok;
    logic [3:0]        uuid_k;
    logic [7:0]        left_dec;
    bbaf_pkg::t_status status;

    always_comb begin
        n_bytes_seen    = r_bytes_seen;
        n_expect_length = r_expect_length;
        n_record_left   = r_record_left;
        n_record_pos    = r_record_pos;
        n_record_is_mfg = r_record_is_mfg;
        n_match_so_far  = r_match_so_far;
        n_major         = r_major;
        n_minor         = r_minor;
        n_outcome       = r_outcome;
        n_decided       = r_decided;
        ok              = 1'b1;
        uuid_k          = 4'(r_record_pos - 5'd5);
        left_dec        = r_record_left - 8'd1;

        if (r_bytes_seen < CNT_W'(MAX_AD_BYTES)) begin
            n_bytes_seen = r_bytes_seen + CNT_W'(1);
            if (!r_decided) begin
                if (r_expect_length) begin
                    if (i_byte == 8'd0) begin
                        n_decided = 1'b1;
                        n_outcome = bbaf_pkg::ST_NODATA;
                    end else begin
                        n_record_left   = i_byte;
                        n_record_pos    = 5'd0;
                        n_record_is_mfg = 1'b0;
                        n_match_so_far  = 1'b0;
                        n_expect_length = 1'b0;
                    end
                end else begin
                    if (r_record_pos == 5'd0) begin
                        n_record_is_mfg = (i_byte == bbaf_pkg::TYPE_MFG);
                        n_match_so_far  = (i_byte == bbaf_pkg::TYPE_MFG);
                    end else if (r_record_pos == 5'd1) begin
                        ok = (i_byte == i_cfg.company_code[7:0]);
                    end else if (r_record_pos == 5'd2) begin
                        ok = (i_byte == i_cfg.company_code[15:8]);
                    end else if (r_record_pos == 5'd3) begin
                        ok = (i_byte == bbaf_pkg::SUBTYPE);
                    end else if (r_record_pos == 5'd4) begin
                        ok = (i_byte == bbaf_pkg::BEACON_LEN);
                    end else if (r_record_pos inside {[5'd5:5'd20]}) begin
                        ok = (i_byte == i_cfg.uuid[uuid_k]);
                    end else if (r_record_pos == 5'd21) begin
                        n_major = {i_byte, 8'd0};
                    end else if (r_record_pos == 5'd22) begin
                        n_major = {r_major[15:8], i_byte};
                    end else if (r_record_pos == 5'd23) begin
                        n_minor = {i_byte, 8'd0};
                    end else if (r_record_pos == 5'd24) begin
                        n_minor = {r_minor[15:8], i_byte};
                    end
                    if (!ok) begin
                        n_match_so_far = 1'b0;
                    end
                    if (r_record_pos < 5'(bbaf_pkg::MATCH_BYTES)) begin
                        n_record_pos = r_record_pos + 5'd1;
                    end
                    n_record_left = left_dec;
                    if (left_dec == 8'd0) begin
                        if (n_record_is_mfg && n_match_so_far &&
                            n_record_pos >= 5'(bbaf_pkg::MATCH_BYTES)) begin
                            n_decided = 1'b1;
                            n_outcome = bbaf_pkg::ST_FOUND;
                        end
                        n_expect_length = 1'b1;
                    end
                end
            end
        end

        if (n_bytes_seen < CNT_W'(bbaf_pkg::MIN_PAYLOAD)) begin
            status = bbaf_pkg::ST_INVALID;
        end else if (n_decided) begin
            status = n_outcome;
        end else if (!n_expect_length) begin
            status = bbaf_pkg::ST_INVALID;
        end else begin
            status = bbaf_pkg::ST_NODATA;
        end

        o_result.status       = status;
        o_result.x_hundredths = (status == bbaf_pkg::ST_FOUND) ? n_major : 16'd0;
        o_result.y_hundredths = (status == bbaf_pkg::ST_FOUND) ? n_minor : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_bytes_seen    <= '0;
            r_expect_length <= 1'b1;
            r_record_left   <= 8'd0;
            r_record_pos    <= 5'd0;
            r_record_is_mfg <= 1'b0;
            r_match_so_far  <= 1'b0;
            r_outcome       <= bbaf_pkg::ST_NODATA;
            r_decided       <= 1'b0;
        end else if (i_step) begin
            r_bytes_seen    <= n_bytes_seen;
            r_expect_length <= n_expect_length;
            r_record_left   <= n_record_left;
            r_record_pos    <= n_record_pos;
            r_record_is_mfg <= n_record_is_mfg;
            r_match_so_far  <= n_match_so_far;
            r_outcome       <= n_outcome;
            r_decided       <= n_decided;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_major <= n_major;
            r_minor <= n_minor;
        end
    end

endmodule

// ===== design/bbaf_checker.sv =====
// Port-level checks for the beacon advertising filter and their binding.
module bbaf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [bbaf_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled result beat changed.");

    a_zero_unless_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != bbaf_pkg::ST_FOUND) |-> o_m_tdata[33:2] == 32'd0)
        else $error("Coordinates are nonzero on a result that is not found.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3 && o_m_tdata[39:34] == 6'd0)
        else $error("Result beat has an undefined status or nonzero fill.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result beat valid right after reset.");

endmodule

bind ble_beacon_advert_filter bbaf_checker u_bbaf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== verif/ble_beacon_advert_filter_tb.sv =====
// Self-checking testbench for the beacon advertising filter.
`timescale 1ns / 1ps

module ble_beacon_advert_filter_tb;
    import bbaf_pkg::*;

    localparam int POS_UUID    = 5;
    localparam int POS_MAJOR   = POS_UUID + UUID_BYTES;
    localparam int MAX_GAP     = 19;
    localparam int IDLE_GAP    = 4;
    localparam int TAIL_CYCLES = 8;
    localparam int DRAIN_LIMIT = 2000;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_BYTES  = 900;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_CFG,
        OP_DRAIN
    } t_op;

    typedef enum int {
        FLT_NONE,
        FLT_TYPE,
        FLT_CO_LO,
        FLT_CO_HI,
        FLT_SUB,
        FLT_LEN,
        FLT_UUID
    } t_fault;

    typedef enum int {
        CS_ZERO,
        CS_ONES,
        CS_RANDOM,
        CS_DEFAULT
    } t_cfg_style;

    typedef struct packed {
        t_op                  kind;
        logic [7:0]           data;
        logic                 last;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata;
    logic                  i_s_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ble_beacon_advert_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_beat       ad_stream_q[$];
    t_result     verdict_q[$];

    // Predictor copy of the registers and of the record walk.
    logic [15:0] cfg_company;
    logic [31:0] cfg_uuid [UUID_WORDS];
    int unsigned seen_cnt;
    bit          want_len;
    logic [7:0]  rec_left;
    int unsigned rec_pos;
    bit          rec_mfg;
    bit          rec_ok;
    logic [15:0] maj_v;
    logic [15:0] min_v;
    t_status     verdict;
    bit          settled;

    // Stimulus builder state: the registers as they will stand when a payload is sent.
    logic [7:0]  ad_buf[$];
    logic [15:0] gen_company;
    logic [31:0] gen_uuid [UUID_WORDS];
    int          n_bytes;
    int          n_pay;

    int          cycle_cnt = 0;
    int          fail_cnt = 0;
    int          rx_cnt = 0;
    int          quiet_cnt = 0;
    int          wait_cnt;
    bit          s_hs = 1'b0;
    bit          c_hs = 1'b0;
    bit          m_hs = 1'b0;
    bit          byte_on = 1'b0;
    bit          cfg_on = 1'b0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int          tx_gap = 0;
    int          rx_wait = 0;

    task automatic walk_clear();
        seen_cnt = 0;
        want_len = 1'b1;
        rec_left = '0;
        rec_pos  = 0;
        rec_mfg  = 1'b0;
        rec_ok   = 1'b0;
        maj_v    = '0;
        min_v    = '0;
        verdict  = ST_NODATA;
        settled  = 1'b0;
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic last);
        t_result     res;
        logic        ok;
        int unsigned k;
        if (seen_cnt < MAX_AD_BYTES_DEF) begin
            seen_cnt++;
            if (!settled) begin
                if (want_len) begin
                    if (b == 8'd0) begin
                        settled = 1'b1;
                        verdict = ST_NODATA;
                    end else begin
                        rec_left = b;
                        rec_pos  = 0;
                        rec_mfg  = 1'b0;
                        rec_ok   = 1'b0;
                        want_len = 1'b0;
                    end
                end else begin
                    ok = 1'b1;
                    if (rec_pos == 0) begin
                        rec_mfg = (b == TYPE_MFG);
                        rec_ok  = rec_mfg;
                    end else if (rec_pos == 1) begin
                        ok = (b == cfg_company[7:0]);
                    end else if (rec_pos == 2) begin
                        ok = (b == cfg_company[15:8]);
                    end else if (rec_pos == 3) begin
                        ok = (b == SUBTYPE);
                    end else if (rec_pos == 4) begin
                        ok = (b == BEACON_LEN);
                    end else if (rec_pos < POS_MAJOR) begin
                        k  = rec_pos - POS_UUID;
                        ok = (b == cfg_uuid[k / 4][31 - 8 * (k % 4) -: 8]);
                    end else if (rec_pos == POS_MAJOR) begin
                        maj_v = {b, 8'h00};
                    end else if (rec_pos == POS_MAJOR + 1) begin
                        maj_v[7:0] = b;
                    end else if (rec_pos == POS_MAJOR + 2) begin
                        min_v = {b, 8'h00};
                    end else if (rec_pos == POS_MAJOR + 3) begin
                        min_v[7:0] = b;
                    end
                    if (!ok) rec_ok = 1'b0;
                    if (rec_pos < MATCH_BYTES) rec_pos++;
                    rec_left--;
                    if (rec_left == 8'd0) begin
                        if (rec_mfg && rec_ok && rec_pos >= MATCH_BYTES) begin
                            settled = 1'b1;
                            verdict = ST_FOUND;
                        end
                        want_len = 1'b1;
                    end
                end
            end
        end
        if (last) begin
            if (seen_cnt < MIN_PAYLOAD) res.status = ST_INVALID;
            else if (settled)           res.status = verdict;
            else if (!want_len)         res.status = ST_INVALID;
            else                        res.status = ST_NODATA;
            res.x_hundredths = (res.status == ST_FOUND) ? maj_v : 16'd0;
            res.y_hundredths = (res.status == ST_FOUND) ? min_v : 16'd0;
            verdict_q.push_back(res);
            walk_clear();
        end
    endtask

    task automatic put_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        t_beat bt;
        bt       = '0;
        bt.kind  = OP_CFG;
        bt.idx   = idx;
        bt.wdata = v;
        ad_stream_q.push_back(bt);
        if (idx == CFG_COMPANY) gen_company = v[15:0];
        else if (idx >= CFG_UUID0 && idx <= CFG_UUID3) gen_uuid[idx - CFG_UUID0] = v;
    endtask

    task automatic put_drain();
        t_beat bt;
        bt      = '0;
        bt.kind = OP_DRAIN;
        ad_stream_q.push_back(bt);
    endtask

    task automatic config_phase(input t_cfg_style style);
        logic [31:0] v;
        logic [31:0] rst_words [UUID_WORDS];
        int          i;
        rst_words = '{UUID0_RST, UUID1_RST, UUID2_RST, UUID3_RST};
        for (i = CFG_COMPANY; i <= CFG_UUID3; i++) begin
            case (style)
                CS_ZERO:   v = '0;
                CS_ONES:   v = '1;
                CS_RANDOM: v = $urandom;
                default:   v = (i == CFG_COMPANY) ? 32'(COMPANY_RST) : rst_words[i - CFG_UUID0];
            endcase
            if (i == CFG_COMPANY) v[31:16] = 16'($urandom);
            if (style != CS_RANDOM || $urandom_range(0, 3) != 0) put_cfg(CFG_IDX_W'(i), v);
        end
        if ($urandom_range(0, 1) == 0)
            put_cfg(CFG_IDX_W'(CFG_UUID3 + $urandom_range(1, 3)), $urandom);
    endtask

    task automatic flush_payload();
        t_beat bt;
        int    i;
        for (i = 0; i < ad_buf.size(); i++) begin
            bt      = '0;
            bt.kind = OP_BYTE;
            bt.data = ad_buf[i];
            bt.last = (i == ad_buf.size() - 1);
            ad_stream_q.push_back(bt);
        end
        n_bytes += ad_buf.size();
        ad_buf.delete();
    endtask

    task automatic add_record(input int len);
        ad_buf.push_back(8'(len));
        repeat (len) ad_buf.push_back(8'($urandom));
    endtask

    task automatic pad_records(input int target);
        while (ad_buf.size() < target) add_record($urandom_range(1, 8));
    endtask

    task automatic add_beacon(input int rec_len, input t_fault fault,
                              input logic [15:0] maj, input logic [15:0] mnr);
        logic [7:0] img [MATCH_BYTES];
        int         i;
        int         pos;
        img[0] = TYPE_MFG;
        img[1] = gen_company[7:0];
        img[2] = gen_company[15:8];
        img[3] = SUBTYPE;
        img[4] = BEACON_LEN;
        for (i = 0; i < UUID_BYTES; i++)
            img[POS_UUID + i] = gen_uuid[i / 4][31 - 8 * (i % 4) -: 8];
        img[POS_MAJOR]     = maj[15:8];
        img[POS_MAJOR + 1] = maj[7:0];
        img[POS_MAJOR + 2] = mnr[15:8];
        img[POS_MAJOR + 3] = mnr[7:0];
        if (fault != FLT_NONE) begin
            pos = (fault == FLT_UUID) ? POS_UUID + $urandom_range(0, UUID_BYTES - 1) : fault - 1;
            img[pos] = img[pos] ^ 8'($urandom_range(1, 255));
        end
        ad_buf.push_back(8'(rec_len));
        for (i = 0; i < rec_len; i++) ad_buf.push_back((i < MATCH_BYTES) ? img[i] : 8'($urandom));
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(20, 32) : MATCH_BYTES;
    endfunction

    function automatic t_fault pick_fault();
        return ($urandom_range(0, 3) == 0) ?
            t_fault'($urandom_range(FLT_TYPE, FLT_UUID)) : FLT_NONE;
    endfunction

    task automatic gen_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            repeat ($urandom_range(0, 2)) add_record($urandom_range(1, 6));
            add_beacon(pick_len(), pick_fault(), 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 3) == 0)
                add_beacon(pick_len(), pick_fault(), 16'($urandom), 16'($urandom));
            case ($urandom_range(0, 7))
                0: begin
                    ad_buf.push_back(8'h00);
                    repeat ($urandom_range(0, 4)) ad_buf.push_back(8'($urandom));
                end
                1: repeat ($urandom_range(1, 5)) void'(ad_buf.pop_back());
                2: add_record($urandom_range(1, 6));
                default: ;
            endcase
        end else if (r < 75) begin
            pad_records($urandom_range(10, 60));
        end else if (r < 88) begin
            repeat ($urandom_range(1, MIN_PAYLOAD - 1)) ad_buf.push_back(8'($urandom));
        end else if (r < 98) begin
            repeat ($urandom_range(MIN_PAYLOAD, 60)) ad_buf.push_back(8'($urandom));
        end else begin
            pad_records($urandom_range(0, 250));
            add_beacon(MATCH_BYTES, FLT_NONE, 16'($urandom), 16'($urandom));
            pad_records($urandom_range(256, 300));
        end
        flush_payload();
    endtask

    // Sample handshakes, check result beats and run the predictor on accepted beats.
    always @(posedge i_clk) begin
        cycle_cnt++;
        s_hs = i_s_tvalid && o_s_tready;
        c_hs = i_cfg_valid && o_cfg_ready;
        m_hs = o_m_tvalid && i_m_tready;
        if (m_hs) begin
            if (verdict_q.size() == 0) begin
                if (fail_cnt < MAX_REPORTS)
                    $display("result beat %0d arrived with nothing expected: data %h",
                             rx_cnt, o_m_tdata);
                fail_cnt++;
            end else if (o_m_tdata[1:0] !== verdict_q[0].status
                         || o_m_tdata[17:2] !== verdict_q[0].x_hundredths
                         || o_m_tdata[33:18] !== verdict_q[0].y_hundredths) begin
                if (fail_cnt < MAX_REPORTS)
                    $display("result beat %0d: expected status %0d x %h y %h, got status %0d x %h y %h",
                             rx_cnt, verdict_q[0].status, verdict_q[0].x_hundredths,
                             verdict_q[0].y_hundredths, o_m_tdata[1:0], o_m_tdata[17:2],
                             o_m_tdata[33:18]);
                fail_cnt++;
                void'(verdict_q.pop_front());
            end else begin
                void'(verdict_q.pop_front());
            end
            rx_cnt++;
        end
        if (c_hs) begin
            if (i_cfg_index == CFG_COMPANY) cfg_company = i_cfg_data[15:0];
            else if (i_cfg_index >= CFG_UUID0 && i_cfg_index <= CFG_UUID3)
                cfg_uuid[i_cfg_index - CFG_UUID0] = i_cfg_data;
        end
        if (s_hs) walk_byte(i_s_tdata, i_s_tlast);
        if (s_hs || verdict_q.size() != 0) quiet_cnt = 0;
        else if (quiet_cnt < IDLE_GAP) quiet_cnt++;
    end

    always @(negedge i_clk) begin
        t_beat head;
        if (i_rst_n) begin
            if (byte_on && s_hs) byte_on = 1'b0;
            if (cfg_on && c_hs) cfg_on = 1'b0;
            if (!byte_on && !cfg_on && ad_stream_q.size() != 0) begin
                head = ad_stream_q[0];
                case (head.kind)
                    OP_BYTE: begin
                        if (tx_gap != 0) begin
                            tx_gap--;
                        end else begin
                            i_s_tdata <= head.data;
                            i_s_tlast <= head.last;
                            byte_on = 1'b1;
                            void'(ad_stream_q.pop_front());
                            if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
                            tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
                        end
                    end
                    OP_CFG: begin
                        if (verdict_q.size() == 0 && quiet_cnt >= IDLE_GAP) begin
                            i_cfg_index <= head.idx;
                            i_cfg_data  <= head.wdata;
                            cfg_on = 1'b1;
                            void'(ad_stream_q.pop_front());
                        end
                    end
                    default: begin
                        if (verdict_q.size() == 0) void'(ad_stream_q.pop_front());
                    end
                endcase
            end
            i_s_tvalid  <= byte_on;
            i_cfg_valid <= cfg_on;
        end
    end

    // After every result beat the receiver holds off for a freshly drawn number of cycles, or not at all in burst mode.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (m_hs) begin
                if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (rx_wait != 0) begin
                rx_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        walk_clear();
        cfg_company = COMPANY_RST;
        cfg_uuid    = '{UUID0_RST, UUID1_RST, UUID2_RST, UUID3_RST};
        gen_company = COMPANY_RST;
        gen_uuid    = '{UUID0_RST, UUID1_RST, UUID2_RST, UUID3_RST};
        n_bytes     = 0;

        add_beacon(MATCH_BYTES, FLT_NONE, 16'hFFFF, 16'h0000);
        flush_payload();
        add_record(2);
        add_beacon(MATCH_BYTES, FLT_NONE, 16'h0000, 16'hFFFF);
        flush_payload();
        ad_buf.push_back(8'h00);
        flush_payload();
        add_record(MIN_PAYLOAD - 2);
        flush_payload();
        add_record(MIN_PAYLOAD - 1);
        flush_payload();
        add_record(10);
        add_record(15);
        ad_buf.push_back(8'h00);
        repeat (3) ad_buf.push_back(8'($urandom));
        flush_payload();
        add_record(3);
        add_beacon(MATCH_BYTES, FLT_NONE, 16'($urandom), 16'($urandom));
        repeat (3) void'(ad_buf.pop_back());
        flush_payload();
        add_record(MIN_PAYLOAD - 1);
        ad_buf.push_back(8'h05);
        flush_payload();
        add_beacon(MATCH_BYTES, FLT_CO_HI, 16'($urandom), 16'($urandom));
        flush_payload();
        add_beacon(MATCH_BYTES - 1, FLT_NONE, 16'($urandom), 16'($urandom));
        flush_payload();
        add_beacon(30, FLT_NONE, 16'h1234, 16'h5678);
        add_beacon(MATCH_BYTES, FLT_NONE, 16'h9ABC, 16'hDEF0);
        flush_payload();
        add_beacon(MATCH_BYTES, FLT_UUID, 16'h1111, 16'h2222);
        add_beacon(MATCH_BYTES, FLT_NONE, 16'h3333, 16'h4444);
        flush_payload();
        add_beacon(MATCH_BYTES, FLT_NONE, 16'($urandom), 16'($urandom));
        ad_buf.push_back(8'h00);
        repeat (4) ad_buf.push_back(8'($urandom));
        flush_payload();
        add_beacon(MATCH_BYTES, FLT_TYPE, 16'($urandom), 16'($urandom));
        add_beacon(MATCH_BYTES, FLT_SUB, 16'($urandom), 16'($urandom));
        add_beacon(MATCH_BYTES, FLT_LEN, 16'($urandom), 16'($urandom));
        add_beacon(MATCH_BYTES, FLT_CO_LO, 16'($urandom), 16'($urandom));
        flush_payload();
        add_beacon(MATCH_BYTES, FLT_NONE, 16'($urandom), 16'($urandom));
        pad_records(300);
        flush_payload();
        pad_records(240);
        add_beacon(MATCH_BYTES, FLT_NONE, 16'($urandom), 16'($urandom));
        pad_records(290);
        flush_payload();
        put_drain();

        n_bytes = 0;
        n_pay   = 0;
        while (n_bytes < RAND_BYTES) begin
            if (n_pay == 0) config_phase(CS_ZERO);
            else if (n_pay == 10) config_phase(CS_ONES);
            else if (n_pay % 10 == 0)
                config_phase(($urandom_range(0, 3) == 0) ? CS_DEFAULT : CS_RANDOM);
            if (n_pay % 17 == 5) put_drain();
            gen_payload();
            n_pay++;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ad_stream_q.size() != 0 || byte_on || cfg_on) @(posedge i_clk);
        wait_cnt = 0;
        while (verdict_q.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            if (fail_cnt < MAX_REPORTS)
                $display("%0d expected result beats never arrived", verdict_q.size());
            fail_cnt += verdict_q.size();
        end
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
